// ===== hw/rtl/pixel_format_color_converter_defines.svh =====
// Assertion macros shared by the pixel format color converter RTL.
// Defining ASSERT_OFF removes every assertion body.
`ifndef PIXEL_FORMAT_COLOR_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_COLOR_CONVERTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PFCC_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define PFCC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PFCC_ASSERT_NOW(lbl, clk, rst, pre, post, msg)
`define PFCC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== hw/rtl/pfcc_pkg.sv =====
// Shared types, codes and constants of the pixel format color converter.
// Used by the interfaces and by every module of the block; no dependencies.
`default_nettype none
package pfcc_pkg;

   localparam int PIXEL_W     = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] FMT_RGB1555  = 2'd0;
   localparam logic [1:0] FMT_XRGB8888 = 2'd1;
   localparam logic [1:0] FMT_RGB565   = 2'd2;

   localparam logic [2:0] REG_SOURCE_FORMAT  = 3'd0;
   localparam logic [2:0] REG_PALETTE_MODE   = 3'd1;
   localparam logic [2:0] REG_CONTRAST_MODE  = 3'd2;
   localparam logic [2:0] REG_SHADE_LIGHTEST = 3'd3;
   localparam logic [2:0] REG_SHADE_LIGHT    = 3'd4;
   localparam logic [2:0] REG_SHADE_DARK     = 3'd5;
   localparam logic [2:0] REG_SHADE_DARKEST  = 3'd6;

   localparam logic [1:0] BAND_DARKEST  = 2'd0;
   localparam logic [1:0] BAND_DARK     = 2'd1;
   localparam logic [1:0] BAND_LIGHT    = 2'd2;
   localparam logic [1:0] BAND_LIGHTEST = 2'd3;

   localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

   localparam logic [1:0]  RESET_SOURCE_FORMAT  = FMT_RGB565;
   localparam logic        RESET_PALETTE_MODE   = 1'b0;
   localparam logic        RESET_CONTRAST_MODE  = 1'b1;
   localparam logic [31:0] RESET_SHADE_LIGHTEST = 32'hFF0F_BC9B;
   localparam logic [31:0] RESET_SHADE_LIGHT    = 32'hFF0F_AC8B;
   localparam logic [31:0] RESET_SHADE_DARK     = 32'hFF30_6230;
   localparam logic [31:0] RESET_SHADE_DARKEST  = 32'hFF0F_380F;

   // 576719 / 2^19 approximates 11 / 10 exactly for magnitudes up to 128.
   localparam logic [19:0] STRETCH_RECIP = 20'd576719;
   localparam int          STRETCH_SHIFT = 19;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_STRETCH,
      OP_PALETTE
   } op_type;

   typedef struct packed {
      logic [1:0]  source_format;
      logic        palette_mode;
      logic        contrast_mode;
      logic [31:0] shade_lightest;
      logic [31:0] shade_light;
      logic [31:0] shade_dark;
      logic [31:0] shade_darkest;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] band;
      logic       frame_end;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pfcc_req_if.sv =====
// Input channel of the pixel format color converter: valid, ready and payload.
// Depends on pfcc_pkg for the pixel width.
`default_nettype none
interface pfcc_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfcc_pkg::PIXEL_W-1:0] pixel_word;
   logic                         frame_end_in;

   modport source (output valid, output pixel_word, output frame_end_in, input ready);
   modport sink (input valid, input pixel_word, input frame_end_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pfcc_rsp_if.sv =====
// Result channel of the pixel format color converter: valid, ready and payload.
// Depends on pfcc_pkg for the pixel width.
`default_nettype none
interface pfcc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pfcc_pkg::PIXEL_W-1:0] out_pixel;
   logic                         frame_end_out;

   modport source (output valid, output out_pixel, output frame_end_out, input ready);
   modport sink (input valid, input out_pixel, input frame_end_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pfcc_front.sv =====
// Front end: accepts input items, decodes the source format and classifies the work.
// Depends on pfcc_pkg and pfcc_req_if.
`default_nettype none
module pfcc_front (
   pfcc_req_if.sink                   req_port,
   input  var pfcc_pkg::cfg_type      cfg,
   input  var pfcc_pkg::queue_status_type q_status,
   output logic                       push,
   output pfcc_pkg::entry_type        entry
);

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [10:0] lum_sum;

   always_comb begin
      unique case (cfg.source_format)
         pfcc_pkg::FMT_XRGB8888: begin
            red   = req_port.pixel_word[23:16];
            green = req_port.pixel_word[15:8];
            blue  = req_port.pixel_word[7:0];
         end
         pfcc_pkg::FMT_RGB1555: begin
            red   = widen5(req_port.pixel_word[14:10]);
            green = widen5(req_port.pixel_word[9:5]);
            blue  = widen5(req_port.pixel_word[4:0]);
         end
         default: begin
            red   = widen5(req_port.pixel_word[15:11]);
            green = widen6(req_port.pixel_word[10:5]);
            blue  = widen5(req_port.pixel_word[4:0]);
         end
      endcase
   end

   assign lum_sum = {2'b00, red, 1'b0} + {3'b000, green} + {1'b0, green, 2'b00}
                    + {3'b000, blue};

   always_comb begin
      entry.red       = red;
      entry.green     = green;
      entry.blue      = blue;
      entry.band      = lum_sum[10:9];
      entry.frame_end = req_port.frame_end_in;
      if (cfg.palette_mode) begin
         entry.op = pfcc_pkg::OP_PALETTE;
      end else if (cfg.contrast_mode) begin
         entry.op = pfcc_pkg::OP_STRETCH;
      end else begin
         entry.op = pfcc_pkg::OP_PASS;
      end
   end

   assign req_port.ready = !q_status.full;
   assign push           = req_port.valid && !q_status.full;

endmodule
`default_nettype wire

// ===== hw/rtl/pfcc_queue.sv =====
// Short FIFO of classified items between the front end and the back end.
// Depends on pfcc_pkg for the entry and status types.
`default_nettype none
module pfcc_queue #(
   parameter int DEPTH = pfcc_pkg::QUEUE_DEPTH
) (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var logic                   push,
   input  var pfcc_pkg::entry_type    entry_in,
   input  var logic                   pop,
   output pfcc_pkg::entry_type        entry_out,
   output pfcc_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pfcc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign entry_out    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pfcc_back.sv =====
// Back end: applies palette, contrast stretch or pass-through and holds the result.
// Depends on pfcc_pkg and pfcc_rsp_if.
`default_nettype none
module pfcc_back (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var pfcc_pkg::cfg_type      cfg,
   input  var pfcc_pkg::entry_type    entry,
   input  var pfcc_pkg::queue_status_type q_status,
   output logic                       pop,
   pfcc_rsp_if.source                 rsp_port
);

   // The stretch works on the magnitude so that the division truncates toward zero.
   function automatic logic [7:0] stretch(input logic [7:0] c);
      logic        neg;
      logic [7:0]  mag;
      logic [27:0] prod;
      logic [8:0]  q;
      logic [8:0]  v;
      neg  = !c[7];
      mag  = c[7] ? {1'b0, c[6:0]} : (8'd128 - c);
      prod = {20'd0, mag} * {8'd0, pfcc_pkg::STRETCH_RECIP};
      q    = prod[pfcc_pkg::STRETCH_SHIFT +: 9];
      if (neg) begin
         v = (q > 9'd128) ? 9'd0 : (9'd128 - q);
      end else begin
         v = 9'd128 + q;
         if (v > 9'd255) begin
            v = 9'd255;
         end
      end
      return v[7:0];
   endfunction

   logic        valid_ff, valid_in;
   logic [31:0] pixel_ff, pixel_in;
   logic        frame_end_ff;
   logic        load;

   assign load     = !valid_ff || rsp_port.ready;
   assign pop      = load && !q_status.empty;
   assign valid_in = load ? !q_status.empty : valid_ff;

   always_comb begin
      case (entry.op)
         pfcc_pkg::OP_PALETTE: begin
            unique case (entry.band)
               pfcc_pkg::BAND_LIGHTEST: pixel_in = cfg.shade_lightest;
               pfcc_pkg::BAND_LIGHT:    pixel_in = cfg.shade_light;
               pfcc_pkg::BAND_DARK:     pixel_in = cfg.shade_dark;
               default:                 pixel_in = cfg.shade_darkest;
            endcase
         end
         pfcc_pkg::OP_STRETCH: begin
            pixel_in = pfcc_pkg::ALPHA_OPAQUE
                       | {8'd0, stretch(entry.blue), stretch(entry.green),
                          stretch(entry.red)};
         end
         default: begin
            pixel_in = pfcc_pkg::ALPHA_OPAQUE
                       | {8'd0, entry.blue, entry.green, entry.red};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pixel_ff     <= pixel_in;
         frame_end_ff <= entry.frame_end;
      end
   end

   assign rsp_port.valid         = valid_ff;
   assign rsp_port.out_pixel     = pixel_ff;
   assign rsp_port.frame_end_out = frame_end_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pixel_format_color_converter.sv =====
// Top level of the pixel format color converter: configuration registers,
// front end, item queue and back end. Depends on pfcc_pkg, the channel
// interfaces and pixel_format_color_converter_defines.svh.
//
// Source pixel words arrive on req_port and leave on rsp_port as 32-bit ABGR
// pixels, with opaque alpha outside palette mode; both channels move an item when
// valid and ready are high at a rising clock edge. Each item gives exactly one
// result, in order. An accepted item goes into the queue and from there into the
// output register; the block takes one item per cycle while the receiver is ready.
// The queue between front and back holds QUEUE_DEPTH items and the back end has
// one output register, so up to QUEUE_DEPTH + 1 items can be in flight; when the
// receiver stalls the output holds and req_port.ready falls once the queue is full.
// Configuration is written through csr_we, csr_index and csr_wdata while the
// block is idle; writes to indexes beyond six are ignored.
// Synchronous reset empties the queue and the output stage and loads the
// register defaults: RGB565 input, palette off, contrast stretch on.
`default_nettype none
`include "pixel_format_color_converter_defines.svh"
module pixel_format_color_converter #(
   parameter int QUEUE_DEPTH = pfcc_pkg::QUEUE_DEPTH
) (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        csr_we,
   input  var logic [2:0]  csr_index,
   input  var logic [31:0] csr_wdata,
   pfcc_req_if.sink        req_port,
   pfcc_rsp_if.source      rsp_port
);

   pfcc_pkg::cfg_type          cfg_ff, cfg_in;
   pfcc_pkg::entry_type        q_entry_in;
   pfcc_pkg::entry_type        q_entry_out;
   pfcc_pkg::queue_status_type q_status;
   logic                       q_push;
   logic                       q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pfcc_pkg::REG_SOURCE_FORMAT:  cfg_in.source_format  = csr_wdata[1:0];
            pfcc_pkg::REG_PALETTE_MODE:   cfg_in.palette_mode   = csr_wdata[0];
            pfcc_pkg::REG_CONTRAST_MODE:  cfg_in.contrast_mode  = csr_wdata[0];
            pfcc_pkg::REG_SHADE_LIGHTEST: cfg_in.shade_lightest = csr_wdata;
            pfcc_pkg::REG_SHADE_LIGHT:    cfg_in.shade_light    = csr_wdata;
            pfcc_pkg::REG_SHADE_DARK:     cfg_in.shade_dark     = csr_wdata;
            pfcc_pkg::REG_SHADE_DARKEST:  cfg_in.shade_darkest  = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format  <= pfcc_pkg::RESET_SOURCE_FORMAT;
         cfg_ff.palette_mode   <= pfcc_pkg::RESET_PALETTE_MODE;
         cfg_ff.contrast_mode  <= pfcc_pkg::RESET_CONTRAST_MODE;
         cfg_ff.shade_lightest <= pfcc_pkg::RESET_SHADE_LIGHTEST;
         cfg_ff.shade_light    <= pfcc_pkg::RESET_SHADE_LIGHT;
         cfg_ff.shade_dark     <= pfcc_pkg::RESET_SHADE_DARK;
         cfg_ff.shade_darkest  <= pfcc_pkg::RESET_SHADE_DARKEST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfcc_front u_front (
      .req_port (req_port),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (q_push),
      .entry    (q_entry_in)
   );

   pfcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (q_entry_in),
      .pop       (q_pop),
      .entry_out (q_entry_out),
      .status    (q_status)
   );

   pfcc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .entry    (q_entry_out),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_port (rsp_port)
   );

   `PFCC_ASSERT_NOW(a_queue_status, clock, reset, 1'b1, !(q_status.full && q_status.empty), "queue reports full and empty at once")
   `PFCC_ASSERT_NEXT(a_accept_fills, clock, reset, req_port.valid && req_port.ready, !q_status.empty, "accepted item missing from queue")
   `PFCC_ASSERT_NEXT(a_pop_shows, clock, reset, q_pop, rsp_port.valid, "popped item not presented")
   `PFCC_ASSERT_NOW(a_hold_no_pop, clock, reset, rsp_port.valid && !rsp_port.ready, !q_pop, "queue popped while result stalled")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pixel_format_color_converter. It streams source pixels under
// many register settings and checks each result pixel against an in-bench conversion.
// Depends on pfcc_pkg and the pfcc_req_if and pfcc_rsp_if channel interfaces.
module testbench;

   localparam logic [2:0] REG_UNMAPPED   = 3'd7;
   localparam logic [1:0] FMT_ALIAS_565  = 2'd3;
   localparam int         RANDOM_PHASES  = 12;
   localparam int         PHASE_ITEMS    = 156;
   localparam int         LONG_HOLD      = 300;
   localparam int         SETTLE_CYCLES  = pfcc_pkg::QUEUE_DEPTH + 4;
   localparam int         IDLE_LIMIT     = 3000;

   typedef struct packed {
      logic [31:0] word;
      logic        frame_end;
   } source_item_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic        frame_end;
   } result_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pfcc_req_if req_ch();
   pfcc_rsp_if rsp_ch();

   pfcc_pkg::cfg_type shadow_cfg = '{pfcc_pkg::RESET_SOURCE_FORMAT,
                                     pfcc_pkg::RESET_PALETTE_MODE,
                                     pfcc_pkg::RESET_CONTRAST_MODE,
                                     pfcc_pkg::RESET_SHADE_LIGHTEST,
                                     pfcc_pkg::RESET_SHADE_LIGHT,
                                     pfcc_pkg::RESET_SHADE_DARK,
                                     pfcc_pkg::RESET_SHADE_DARKEST};

   source_item_type source_items[$];
   result_item_type awaited_pixels[$];
   int              send_gap = 0;
   int              hold_left = 0;
   int              idle_odds = 0;
   int              error_count = 0;
   int              idle_cycles = 0;
   bit              long_hold_request = 1'b0;

   pixel_format_color_converter u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] stretch_channel(input logic [7:0] c);
      int offset;
      int level;
      offset = int'(c) - 128;
      level = offset * 110 / 100 + 128;
      if (level < 0) begin
         level = 0;
      end else if (level > 255) begin
         level = 255;
      end
      return level[7:0];
   endfunction

   function automatic logic [31:0] convert_pixel(input pfcc_pkg::cfg_type cfg,
                                                 input logic [31:0] w);
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      int unsigned      lum;
      logic [1:0]       band;
      pfcc_pkg::op_type op;
      logic [31:0]      pixel;
      case (cfg.source_format)
         pfcc_pkg::FMT_XRGB8888: begin
            red = w[23:16];
            green = w[15:8];
            blue = w[7:0];
         end
         pfcc_pkg::FMT_RGB1555: begin
            red = widen5(w[14:10]);
            green = widen5(w[9:5]);
            blue = widen5(w[4:0]);
         end
         default: begin
            red = widen5(w[15:11]);
            green = widen6(w[10:5]);
            blue = widen5(w[4:0]);
         end
      endcase
      if (cfg.palette_mode) begin
         op = pfcc_pkg::OP_PALETTE;
      end else if (cfg.contrast_mode) begin
         op = pfcc_pkg::OP_STRETCH;
      end else begin
         op = pfcc_pkg::OP_PASS;
      end
      lum = (2 * red + 5 * green + blue) >> 3;
      if (lum >= 192) begin
         band = pfcc_pkg::BAND_LIGHTEST;
      end else if (lum >= 128) begin
         band = pfcc_pkg::BAND_LIGHT;
      end else if (lum >= 64) begin
         band = pfcc_pkg::BAND_DARK;
      end else begin
         band = pfcc_pkg::BAND_DARKEST;
      end
      case (op)
         pfcc_pkg::OP_PALETTE: begin
            case (band)
               pfcc_pkg::BAND_LIGHTEST: pixel = cfg.shade_lightest;
               pfcc_pkg::BAND_LIGHT:    pixel = cfg.shade_light;
               pfcc_pkg::BAND_DARK:     pixel = cfg.shade_dark;
               default:                 pixel = cfg.shade_darkest;
            endcase
         end
         pfcc_pkg::OP_STRETCH: begin
            pixel = pfcc_pkg::ALPHA_OPAQUE
                    | {8'h00, stretch_channel(blue), stretch_channel(green),
                       stretch_channel(red)};
         end
         default: begin
            pixel = pfcc_pkg::ALPHA_OPAQUE | {8'h00, blue, green, red};
         end
      endcase
      return pixel;
   endfunction

   function automatic void queue_word(input logic [31:0] w, input logic frame_end);
      source_item_type item;
      item.word = w;
      item.frame_end = frame_end;
      source_items.push_back(item);
   endfunction

   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         pfcc_pkg::REG_SOURCE_FORMAT:  shadow_cfg.source_format = data[1:0];
         pfcc_pkg::REG_PALETTE_MODE:   shadow_cfg.palette_mode = data[0];
         pfcc_pkg::REG_CONTRAST_MODE:  shadow_cfg.contrast_mode = data[0];
         pfcc_pkg::REG_SHADE_LIGHTEST: shadow_cfg.shade_lightest = data;
         pfcc_pkg::REG_SHADE_LIGHT:    shadow_cfg.shade_light = data;
         pfcc_pkg::REG_SHADE_DARK:     shadow_cfg.shade_dark = data;
         pfcc_pkg::REG_SHADE_DARKEST:  shadow_cfg.shade_darkest = data;
         default: ;
      endcase
   endtask

   // Polled at the falling edge so that the driver's updates at the rising edge have settled.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (source_items.size() != 0 || req_ch.valid || awaited_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      source_item_type next_item;
      result_item_type awaited;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited.pixel = convert_pixel(shadow_cfg, req_ch.pixel_word);
            awaited.frame_end = req_ch.frame_end_in;
            awaited_pixels.push_back(awaited);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
               send_gap = $urandom_range(14, 0);
               req_ch.valid <= 1'b0;
            end else if (source_items.size() != 0) begin
               next_item = source_items.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.pixel_word <= next_item.word;
               req_ch.frame_end_in <= next_item.frame_end;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_item_type awaited;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_pixels.size() == 0) begin
               $error("unexpected item: out_pixel %h", rsp_ch.out_pixel);
               error_count++;
            end else begin
               awaited = awaited_pixels.pop_front();
               if (rsp_ch.out_pixel !== awaited.pixel) begin
                  $error("out_pixel: expected %h, actual %h", awaited.pixel, rsp_ch.out_pixel);
                  error_count++;
               end
               if (rsp_ch.frame_end_out !== awaited.frame_end) begin
                  $error("frame_end_out: expected %b, actual %b", awaited.frame_end,
                         rsp_ch.frame_end_out);
                  error_count++;
               end
            end
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
            hold_left = $urandom_range(14, 0);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [31:0] item_word;
      logic [31:0] shade;
      logic [7:0]  gray;
      req_ch.valid = 1'b0;
      req_ch.pixel_word = '0;
      req_ch.frame_end_in = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: RGB565 input with the contrast stretch.
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h0000_F800, 1'b0);
      queue_word(32'hFFFF_07E0, 1'b0);
      queue_word(32'h0000_001F, 1'b1);
      wait_drained();

      write_reg(pfcc_pkg::REG_SOURCE_FORMAT, 32'(pfcc_pkg::FMT_XRGB8888));
      write_reg(pfcc_pkg::REG_CONTRAST_MODE, 32'd0);
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h00FF_0000, 1'b0);
      queue_word(32'h0000_FF00, 1'b0);
      queue_word(32'h0000_00FF, 1'b0);
      queue_word(32'h5A80_4020, 1'b1);
      wait_drained();

      write_reg(pfcc_pkg::REG_SOURCE_FORMAT, 32'(pfcc_pkg::FMT_RGB1555));
      write_reg(pfcc_pkg::REG_CONTRAST_MODE, 32'd1);
      queue_word(32'h0000_FFFF, 1'b0);
      queue_word(32'h0000_7FFF, 1'b0);
      queue_word(32'hFFFF_8000, 1'b1);
      queue_word(32'h0000_0421, 1'b0);
      wait_drained();

      // The spare format code decodes as RGB565.
      write_reg(pfcc_pkg::REG_SOURCE_FORMAT, 32'(FMT_ALIAS_565));
      queue_word(32'h0000_F81F, 1'b0);
      queue_word(32'h0000_07E0, 1'b1);
      wait_drained();

      // Palette mode wins over the contrast stretch; gray levels sit on the band edges.
      write_reg(pfcc_pkg::REG_SOURCE_FORMAT, 32'(pfcc_pkg::FMT_XRGB8888));
      write_reg(pfcc_pkg::REG_PALETTE_MODE, 32'd1);
      for (int k = 0; k < 8; k++) begin
         case (k)
            0: gray = 8'd0;
            1: gray = 8'd63;
            2: gray = 8'd64;
            3: gray = 8'd127;
            4: gray = 8'd128;
            5: gray = 8'd191;
            6: gray = 8'd192;
            default: gray = 8'd255;
         endcase
         queue_word({8'h00, gray, gray, gray}, k == 7);
      end
      wait_drained();

      write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
      queue_word(32'h00C8_C8C8, 1'b0);
      queue_word(32'h000A_0A0A, 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         idle_odds = 0;
         write_reg(pfcc_pkg::REG_SOURCE_FORMAT, ($urandom() & ~32'h3) | 32'(p % 4));
         write_reg(pfcc_pkg::REG_PALETTE_MODE, ($urandom() & ~32'h1) | 32'((p / 4) % 2));
         write_reg(pfcc_pkg::REG_CONTRAST_MODE, ($urandom() & ~32'h1) | 32'((p / 2) % 2));
         for (int r = 0; r < 4; r++) begin
            if (p == 5) begin
               shade = 32'h0000_0000;
            end else if (p == 6) begin
               shade = 32'hFFFF_FFFF;
            end else begin
               shade = $urandom();
            end
            write_reg(pfcc_pkg::REG_SHADE_LIGHTEST + 3'(r), shade);
         end
         if (p % 3 == 0) begin
            write_reg(REG_UNMAPPED, $urandom());
         end
         case (p % 3)
            0: idle_odds = 0;
            1: idle_odds = 3;
            default: idle_odds = 10;
         endcase
         if (p == RANDOM_PHASES - 1) begin
            idle_odds = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            item_word = $urandom();
            if ($urandom_range(3, 0) == 0) begin
               for (int b = 0; b < 4; b++) begin
                  case ($urandom_range(2, 0))
                     0: item_word[8*b +: 8] = 8'h00;
                     1: item_word[8*b +: 8] = 8'hFF;
                     default: ;
                  endcase
               end
            end
            queue_word(item_word, $urandom_range(7, 0) == 0);
         end
         // The receiver holds off while the whole phase is offered, so the input backs up.
         if (p == 5) begin
            long_hold_request = 1'b1;
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
